>>> hw/rtl/udcss_pkg.sv
// shared types and constants for the up/down decimal counter with digit scan
// no dependencies
package udcss_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int SCAN_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int COUNT_W    = 14;
  localparam int DIGIT_W    = 4;
  localparam int SEL_W      = 4;
  localparam int BTN_W      = 2;
  localparam int RECIP_W    = 16;
  localparam int RECIP_SH   = 19;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(9999);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(10);
  localparam logic [SEL_W-1:0]   SELECT_TOP  = SEL_W'(8);
  localparam logic [RECIP_W-1:0] RECIP_TEN   = RECIP_W'(52429);
  localparam logic [SCAN_W-1:0]  SCAN_LAST   = SCAN_W'(NUM_DIGITS - 1);

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_UP     = 2'd1,
    CMD_DOWN   = 2'd2,
    CMD_PRESET = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load_in;
    logic apply_cmd;
    logic div_step;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [COUNT_W-1:0] div10(input logic [COUNT_W-1:0] v);
    logic [COUNT_W+RECIP_W-1:0] p;
    p = (COUNT_W+RECIP_W)'(v) * (COUNT_W+RECIP_W)'(RECIP_TEN);
    return COUNT_W'(p >> RECIP_SH);
  endfunction

  function automatic logic [COUNT_W-1:0] inc_wrap(input logic [COUNT_W-1:0] v);
    return (v >= COUNT_MAX) ? '0 : v + COUNT_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] dec_wrap(input logic [COUNT_W-1:0] v);
    return ((v == '0) || (v > COUNT_MAX)) ? COUNT_MAX : v - COUNT_W'(1);
  endfunction

endpackage

>>> hw/rtl/udcss_in_if.sv
// input channel: one scan tick transaction with command and button levels
// depends on udcss_pkg
interface udcss_in_if;
  import udcss_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [COUNT_W-1:0] preset_value;
  logic [BTN_W-1:0]   button_levels;

  modport source (output valid, cmd, preset_value, button_levels, input ready);
  modport sink   (input valid, cmd, preset_value, button_levels, output ready);
endinterface

>>> hw/rtl/udcss_out_if.sv
// output channel: one display result transaction per scan tick
// depends on udcss_pkg
interface udcss_out_if;
  import udcss_pkg::*;

  logic               valid;
  logic               ready;
  logic [SEL_W-1:0]   digit_select;
  logic [DIGIT_W-1:0] digit_value;
  logic [COUNT_W-1:0] count_value;

  modport source (output valid, digit_select, digit_value, count_value, input ready);
  modport sink   (input valid, digit_select, digit_value, count_value, output ready);
endinterface

>>> hw/rtl/updown_decimal_counter_seg_scan.sv
// Four-digit up/down decimal counter (0..9999, reset value 10) with a
// multiplexed digit scan. Each tick transaction applies its command, advances
// the scan index and returns the one-hot digit select, that digit and the
// count; falling button edges then step the count for the next tick. A tick
// passes from acceptance through command, digit extraction and result states;
// the divide-by-ten unit strips one decimal digit per cycle down to digit k,
// the new scan index (0..3); the next tick is taken the cycle after the result
// is registered, while that result may still wait at the output.
// depends on udcss_pkg, udcss_in_if, udcss_out_if, udcss_ctrl, udcss_dp
module updown_decimal_counter_seg_scan (
  input logic          clk,
  input logic          rst,
  udcss_in_if.sink     tick,
  udcss_out_if.source  disp
);
  import udcss_pkg::*;

  ctrl_t   ctrl;
  status_t stat;

  udcss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (tick.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  udcss_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_cmd     (tick.cmd),
    .in_preset  (tick.preset_value),
    .in_buttons (tick.button_levels),
    .out_valid  (disp.valid),
    .out_ready  (disp.ready),
    .out_select (disp.digit_select),
    .out_digit  (disp.digit_value),
    .out_count  (disp.count_value)
  );
endmodule

>>> hw/rtl/udcss_ctrl.sv
// controller state machine sequencing command, digit extraction and result
// depends on udcss_pkg
module udcss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  udcss_pkg::status_t stat,
  output udcss_pkg::ctrl_t   ctrl
);
  import udcss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CMD;
        S_CMD:  state <= S_DIV;
        S_DIV:  if (stat.div_done) state <= S_EMIT;
        S_EMIT: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready       = (state == S_IDLE);
    ctrl.load_in   = (state == S_IDLE) && in_valid;
    ctrl.apply_cmd = (state == S_CMD);
    ctrl.div_step  = (state == S_DIV) && !stat.div_done;
    ctrl.emit      = (state == S_EMIT) && stat.out_free;
  end

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.load_in, ctrl.apply_cmd, ctrl.div_step, ctrl.emit}))
    else $error("more than one datapath command");

  a_cmd_to_div: assert property (@(posedge clk) disable iff (rst)
    ctrl.apply_cmd |=> (state == S_DIV))
    else $error("command not followed by digit extraction");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> in_ready)
    else $error("not ready after result");
endmodule

>>> hw/rtl/udcss_dp.sv
// datapath: count, scan index, button history, divide-by-ten unit, result register
// depends on udcss_pkg
module udcss_dp (
  input  logic               clk,
  input  logic               rst,
  input  udcss_pkg::ctrl_t   ctrl,
  output udcss_pkg::status_t stat,
  input  logic [1:0]                       in_cmd,
  input  logic [udcss_pkg::COUNT_W-1:0]    in_preset,
  input  logic [udcss_pkg::BTN_W-1:0]      in_buttons,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [udcss_pkg::SEL_W-1:0]      out_select,
  output logic [udcss_pkg::DIGIT_W-1:0]    out_digit,
  output logic [udcss_pkg::COUNT_W-1:0]    out_count
);
  import udcss_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [SCAN_W-1:0]  scan_index;
  logic [BTN_W-1:0]   prev_buttons;
  cmd_t               cmd_r;
  logic [COUNT_W-1:0] preset_r;
  logic [BTN_W-1:0]   btn_r;
  logic [COUNT_W-1:0] work;
  logic [SCAN_W-1:0]  steps;

  logic [COUNT_W-1:0] quot;
  logic [COUNT_W-1:0] cmd_count;
  logic [COUNT_W-1:0] btn_count;
  logic [SCAN_W-1:0]  scan_next;
  logic [BTN_W-1:0]   fall;
  logic [DIGIT_W-1:0] digit;

  always_comb begin
    quot  = div10(work);
    digit = DIGIT_W'(work - ((quot << 3) + (quot << 1)));
    unique case (cmd_r)
      CMD_UP:     cmd_count = inc_wrap(count);
      CMD_DOWN:   cmd_count = dec_wrap(count);
      CMD_PRESET: cmd_count = (preset_r > COUNT_MAX) ? COUNT_MAX : preset_r;
      default:    cmd_count = count;
    endcase
    scan_next = (scan_index == SCAN_LAST) ? '0 : scan_index + SCAN_W'(1);
    fall      = prev_buttons & ~btn_r;
    btn_count = count;
    if (fall[0]) btn_count = inc_wrap(btn_count);
    if (fall[1]) btn_count = dec_wrap(btn_count);
    stat.div_done = (steps == '0);
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= COUNT_RESET;
      scan_index   <= '0;
      prev_buttons <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (ctrl.apply_cmd) begin
        count      <= cmd_count;
        scan_index <= scan_next;
      end
      if (ctrl.emit) begin
        out_valid    <= 1'b1;
        count        <= btn_count;
        prev_buttons <= btn_r;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r    <= cmd_t'(in_cmd);
      preset_r <= in_preset;
      btn_r    <= in_buttons;
    end
    if (ctrl.apply_cmd) begin
      work  <= cmd_count;
      steps <= scan_next;
    end
    if (ctrl.div_step) begin
      work  <= quot;
      steps <= steps - SCAN_W'(1);
    end
    if (ctrl.emit) begin
      out_select <= SEL_W'(SELECT_TOP >> scan_index);
      out_digit  <= digit;
      out_count  <= count;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("count out of decimal range");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_digit <= DIGIT_W'(9)))
    else $error("digit value not decimal");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> out_valid)
    else $error("result register not loaded");
endmodule
